// File: design/dssp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dssp_pkg;

	localparam int unsigned MODE_W   = 2;
	localparam int unsigned VID_W    = 10;
	localparam int unsigned WEIGHT_W = 16;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned DIST_W   = 32;

	localparam int unsigned ROOT_W   = 10;
	localparam int unsigned BWIDTH_W = 16;
	localparam int unsigned VCOUNT_W = 11;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 16;

	localparam logic [MODE_W-1:0] MODE_ADD  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_RUN  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_READ = 2'd2;

	localparam logic [STATUS_W-1:0] ST_EDGE_STORED = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EDGE_FULL   = 2'd1;
	localparam logic [STATUS_W-1:0] ST_RUN_DONE    = 2'd2;
	localparam logic [STATUS_W-1:0] ST_READ_DATA   = 2'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_ROOT   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BWIDTH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_VCOUNT = 2'd2;

	typedef struct packed {
		logic [MODE_W-1:0]   mode;
		logic [VID_W-1:0]    src_vertex;
		logic [VID_W-1:0]    dst_vertex;
		logic [WEIGHT_W-1:0] weight;
	} in_item_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [DIST_W-1:0]   distance;
	} out_item_t;

endpackage

`default_nettype wire

// File: design/dssp_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface dssp_in_if;
	logic               valid;
	logic               ready;
	dssp_pkg::in_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface dssp_out_if;
	logic                valid;
	logic                ready;
	dssp_pkg::out_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: design/delta_stepping_shortest_paths.sv
// delta-stepping shortest paths over a stored directed graph
// in_ch carries commands: add edge, run, read distance; out_ch returns one
// beat per add, run and read command (mode 3 is taken and gives nothing).
// the user must write configuration (root vertex, bucket width, vertex
// count) on the cfg port only while idle; the block does not enforce it.
// cfg writes take effect at once. an add reads the list head, then writes
// the edge and new head; a read reads the distance memory; both wait on the
// registered memory read. a refused add or a read outside the vertex count
// answers in the next cycle. a run first initialises all MAX_VERTICES
// entries, then per bucket runs a min-finding sweep, a bucket bound
// division, a marking sweep and relaxation passes over each active vertex
// and its edges, repeated while the bucket refills; a final sweep finds no
// bucket and reports run done.
// after reset all MAX_VERTICES list heads are cleared, one entry a cycle,
// with in_ch not ready; cfg writes are still taken.
// results sit in an output register; the next command is taken in the cycle
// the previous result leaves, and while out_ch stalls no command is taken.
`timescale 1ns / 1ps
`default_nettype none

module delta_stepping_shortest_paths #(
	parameter int MAX_VERTICES = 1024,
	parameter int MAX_EDGES    = 4096,
	parameter int WEIGHT_BITS  = 16,
	parameter int DIST_BITS    = 32
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 cfg_we,
	input  wire  [dssp_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire  [dssp_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	dssp_in_if.sink                             in_ch,
	dssp_out_if.source                          out_ch
);

	localparam int VW  = $clog2(MAX_VERTICES);
	localparam int NW  = $clog2(MAX_VERTICES + 1);
	localparam int EW  = $clog2(MAX_EDGES);
	localparam int LW  = $clog2(MAX_EDGES + 1);
	localparam int DCW = $clog2(DIST_BITS);
	localparam int HW  = DIST_BITS + 17;
	localparam logic [DIST_BITS-1:0] DALL = '1;

	typedef enum logic [14:0] {
		S_CLEAR = 15'h0001,
		S_IDLE  = 15'h0002,
		S_ADD   = 15'h0004,
		S_READ  = 15'h0008,
		S_INIT  = 15'h0010,
		S_ROOT  = 15'h0020,
		S_FIND  = 15'h0040,
		S_DIV   = 15'h0080,
		S_BND   = 15'h0100,
		S_MARK  = 15'h0200,
		S_SCAN  = 15'h0400,
		S_CHK   = 15'h0800,
		S_EDGE  = 15'h1000,
		S_EDGEW = 15'h2000,
		S_TGT   = 15'h4000
	} state_t;

	state_t state_q;

	logic [dssp_pkg::ROOT_W-1:0]   root_q;
	logic [dssp_pkg::BWIDTH_W-1:0] bwidth_q;
	logic [dssp_pkg::VCOUNT_W-1:0] vcount_q;

	// memories
	logic [DIST_BITS-1:0]   dist_mem  [MAX_VERTICES];
	logic                   inb_mem   [MAX_VERTICES];
	logic                   act0_mem  [MAX_VERTICES];
	logic                   act1_mem  [MAX_VERTICES];
	logic [LW-1:0]          head_mem  [MAX_VERTICES];
	logic [LW-1:0]          enext_mem [MAX_EDGES];
	logic [VW-1:0]          etgt_mem  [MAX_EDGES];
	logic [WEIGHT_BITS-1:0] ewt_mem   [MAX_EDGES];

	logic [DIST_BITS-1:0]   dist_rd_q;
	logic                   inb_rd_q, act0_rd_q, act1_rd_q;
	logic [LW-1:0]          head_rd_q, enext_rd_q;
	logic [VW-1:0]          etgt_rd_q;
	logic [WEIGHT_BITS-1:0] ewt_rd_q;

	logic [VW-1:0]        vra;
	logic [EW-1:0]        era;
	logic                 dist_we, inb_we, inb_wd, act0_we, act0_wd, act1_we, act1_wd, head_we;
	logic                 edge_we;
	logic [VW-1:0]        dist_wa, inb_wa, act_wa, head_wa;
	logic [DIST_BITS-1:0] dist_wd;
	logic [LW-1:0]        head_wd;

	// control and run registers
	logic [LW-1:0]          fill_q;
	logic [VW-1:0]          add_src_q, add_dst_q;
	logic [WEIGHT_BITS-1:0] add_wt_q;
	logic [NW-1:0]          cnt_q, sw_q, v_q;
	logic                   vld_s1;
	logic [VW-1:0]          va_s1;
	logic                   sel_q, any_q, found_q, tok_q;
	logic [DIST_BITS-1:0]   dv_q, cand_q, dmin_q, dsh_q;
	logic [LW-1:0]          link_q, nxt_q;
	logic [VW-1:0]          tgt_q;
	logic [16:0]            rem_q;
	logic [DCW-1:0]         dcnt_q;
	logic [HW-1:0]          hi_q;
	logic                   out_valid_q;
	dssp_pkg::out_item_t    out_data_q;

	// derived configuration
	logic [31:0]   vc32, n32;
	logic [NW-1:0] n_w;
	logic [15:0]   delta_w;
	always_comb begin
		vc32 = 32'(vcount_q);
		if (vc32 == 32'd0) begin
			n32 = 32'd1;
		end else if (vc32 > 32'(MAX_VERTICES)) begin
			n32 = 32'(MAX_VERTICES);
		end else begin
			n32 = vc32;
		end
		n_w = n32[NW-1:0];
		delta_w = (bwidth_q == '0) ? 16'd1 : bwidth_q;
	end

	logic [31:0] src32, dst32, root32, wt32;
	logic        src_ok, dst_ok, src_in_n, root_in_n, full_w;
	assign src32     = 32'(in_ch.data.src_vertex);
	assign dst32     = 32'(in_ch.data.dst_vertex);
	assign root32    = 32'(root_q);
	assign wt32      = 32'(in_ch.data.weight);
	assign src_ok    = src32 < 32'(MAX_VERTICES);
	assign dst_ok    = dst32 < 32'(MAX_VERTICES);
	assign src_in_n  = src32 < 32'(n_w);
	assign root_in_n = root32 < 32'(n_w);
	assign full_w    = fill_q == LW'(MAX_EDGES);

	logic act_rd, take, accept, sw_issue, sw_done, sweep_go, res_set;
	assign act_rd   = sel_q ? act1_rd_q : act0_rd_q;
	assign take     = out_valid_q && out_ch.ready;
	assign in_ch.ready = (state_q == S_IDLE) && (!out_valid_q || out_ch.ready);
	assign accept   = in_ch.valid && in_ch.ready;
	assign sw_issue = sw_q < n_w;
	assign sw_done  = !sw_issue && !vld_s1;
	assign sweep_go = (state_q == S_FIND || state_q == S_MARK) && sw_issue;
	assign out_ch.valid = out_valid_q;
	assign out_ch.data  = out_data_q;

	// a result is ready for the output register
	assign res_set = (state_q == S_IDLE && accept &&
		((in_ch.data.mode == dssp_pkg::MODE_ADD && (full_w || !src_ok || !dst_ok)) ||
		 (in_ch.data.mode == dssp_pkg::MODE_READ && !src_in_n))) ||
		state_q == S_ADD || state_q == S_READ ||
		(state_q == S_FIND && sw_done && !found_q);

	logic       rd_in_bkt;
	assign rd_in_bkt = HW'(dist_rd_q) < hi_q;

	// saturating relaxation sum
	logic [64:0]          sum65;
	logic [DIST_BITS-1:0] cand_w;
	assign sum65  = 65'(dv_q) + 65'(ewt_rd_q);
	assign cand_w = (sum65 >= 65'(DALL)) ? (DALL - DIST_BITS'(1)) : sum65[DIST_BITS-1:0];

	// bucket bound division step
	logic [16:0] dtry;
	logic [16:0] drem;
	assign dtry = {rem_q[15:0], dsh_q[DIST_BITS-1]};
	assign drem = (dtry >= {1'b0, delta_w}) ? (dtry - {1'b0, delta_w}) : dtry;

	logic [LW-1:0] lm1;
	logic [63:0]   rd64;
	assign lm1  = link_q - LW'(1);
	assign era  = lm1[EW-1:0];
	assign rd64 = 64'(dist_rd_q);

	always_comb begin
		unique case (state_q)
			S_IDLE:         vra = src32[VW-1:0];
			S_FIND, S_MARK: vra = sw_q[VW-1:0];
			S_SCAN:         vra = v_q[VW-1:0];
			S_EDGEW:        vra = etgt_rd_q;
			default:        vra = '0;
		endcase
	end

	always_comb begin
		dist_we = 1'b0; dist_wa = '0; dist_wd = '0;
		inb_we  = 1'b0; inb_wa  = '0; inb_wd  = 1'b0;
		act0_we = 1'b0; act0_wd = 1'b0;
		act1_we = 1'b0; act1_wd = 1'b0; act_wa = '0;
		head_we = 1'b0; head_wa = '0; head_wd = '0;
		edge_we = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				head_we = 1'b1; head_wa = cnt_q[VW-1:0];
			end
			S_ADD: begin
				edge_we = 1'b1;
				head_we = 1'b1; head_wa = add_src_q; head_wd = fill_q + LW'(1);
			end
			S_INIT: begin
				dist_we = 1'b1; dist_wa = cnt_q[VW-1:0]; dist_wd = DALL;
				inb_we  = 1'b1; inb_wa  = cnt_q[VW-1:0];
				act0_we = 1'b1; act1_we = 1'b1; act_wa = cnt_q[VW-1:0];
			end
			S_ROOT: begin
				dist_we = root_in_n; dist_wa = root32[VW-1:0];
				inb_we  = root_in_n; inb_wa  = root32[VW-1:0]; inb_wd = 1'b1;
			end
			S_FIND: begin
				inb_we = vld_s1 && inb_rd_q && rd_in_bkt; inb_wa = va_s1;
			end
			S_MARK: begin
				act_wa  = va_s1;
				act0_we = vld_s1 && !sel_q; act1_we = vld_s1 && sel_q;
				act0_wd = inb_rd_q && rd_in_bkt; act1_wd = inb_rd_q && rd_in_bkt;
			end
			S_CHK: begin
				act_wa  = v_q[VW-1:0];
				act0_we = act_rd && !sel_q; act1_we = act_rd && sel_q;
			end
			S_TGT: begin
				if (tok_q && cand_q < dist_rd_q) begin
					dist_we = 1'b1; dist_wa = tgt_q; dist_wd = cand_q;
					inb_we  = 1'b1; inb_wa  = tgt_q; inb_wd = 1'b1;
					act_wa  = tgt_q;
					act0_we = sel_q && (HW'(cand_q) < hi_q); act0_wd = 1'b1;
					act1_we = !sel_q && (HW'(cand_q) < hi_q); act1_wd = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (dist_we) dist_mem[dist_wa] <= dist_wd;
		if (inb_we)  inb_mem[inb_wa]   <= inb_wd;
		if (act0_we) act0_mem[act_wa]  <= act0_wd;
		if (act1_we) act1_mem[act_wa]  <= act1_wd;
		if (head_we) head_mem[head_wa] <= head_wd;
		dist_rd_q <= dist_mem[vra];
		inb_rd_q  <= inb_mem[vra];
		act0_rd_q <= act0_mem[vra];
		act1_rd_q <= act1_mem[vra];
		head_rd_q <= head_mem[vra];
	end

	always_ff @(posedge clk) begin
		if (edge_we) begin
			enext_mem[fill_q[EW-1:0]] <= head_rd_q;
			etgt_mem[fill_q[EW-1:0]]  <= add_dst_q;
			ewt_mem[fill_q[EW-1:0]]   <= add_wt_q;
		end
		enext_rd_q <= enext_mem[era];
		etgt_rd_q  <= etgt_mem[era];
		ewt_rd_q   <= ewt_mem[era];
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			add_src_q <= src32[VW-1:0];
			add_dst_q <= dst32[VW-1:0];
			add_wt_q  <= wt32[WEIGHT_BITS-1:0];
		end
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (in_ch.data.mode == dssp_pkg::MODE_READ) begin
						out_data_q.distance <= '1;
						out_data_q.status   <= dssp_pkg::ST_READ_DATA;
					end else begin
						out_data_q.distance <= '0;
						out_data_q.status   <= dssp_pkg::ST_EDGE_FULL;
					end
				end
			end
			S_ADD: begin
				out_data_q.distance <= '0;
				out_data_q.status   <= dssp_pkg::ST_EDGE_STORED;
			end
			S_READ: begin
				out_data_q.distance <= rd64[31:0];
				out_data_q.status   <= dssp_pkg::ST_READ_DATA;
			end
			S_FIND: begin
				out_data_q.distance <= '0;
				out_data_q.status   <= dssp_pkg::ST_RUN_DONE;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			root_q      <= '0;
			bwidth_q    <= 16'd4;
			vcount_q    <= 11'd1024;
			fill_q      <= '0;
			cnt_q       <= '0;
			sw_q        <= '0;
			v_q         <= '0;
			vld_s1      <= 1'b0;
			va_s1       <= '0;
			sel_q       <= 1'b0;
			any_q       <= 1'b0;
			found_q     <= 1'b0;
			tok_q       <= 1'b0;
			dv_q        <= '0;
			cand_q      <= '0;
			dmin_q      <= '0;
			dsh_q       <= '0;
			link_q      <= '0;
			nxt_q       <= '0;
			tgt_q       <= '0;
			rem_q       <= '0;
			dcnt_q      <= '0;
			hi_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					dssp_pkg::CFG_ROOT:   root_q   <= cfg_wdata[dssp_pkg::ROOT_W-1:0];
					dssp_pkg::CFG_BWIDTH: bwidth_q <= cfg_wdata[dssp_pkg::BWIDTH_W-1:0];
					dssp_pkg::CFG_VCOUNT: vcount_q <= cfg_wdata[dssp_pkg::VCOUNT_W-1:0];
					default: begin
					end
				endcase
			end
			out_valid_q <= res_set || (out_valid_q && !take);

			// sweep pipeline
			vld_s1 <= sweep_go;
			if (sweep_go) begin
				sw_q  <= sw_q + NW'(1);
				va_s1 <= sw_q[VW-1:0];
			end

			unique case (state_q)
				S_CLEAR: begin
					cnt_q <= cnt_q + NW'(1);
					if (cnt_q == NW'(MAX_VERTICES - 1)) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (accept) begin
						unique case (in_ch.data.mode)
							dssp_pkg::MODE_ADD: begin
								if (!(full_w || !src_ok || !dst_ok)) state_q <= S_ADD;
							end
							dssp_pkg::MODE_RUN: begin
								cnt_q   <= '0;
								state_q <= S_INIT;
							end
							dssp_pkg::MODE_READ: begin
								if (src_in_n) state_q <= S_READ;
							end
							default: begin
							end
						endcase
					end
				end
				S_ADD: begin
					fill_q  <= fill_q + LW'(1);
					state_q <= S_IDLE;
				end
				S_READ: begin
					state_q <= S_IDLE;
				end
				S_INIT: begin
					cnt_q <= cnt_q + NW'(1);
					if (cnt_q == NW'(MAX_VERTICES - 1)) state_q <= S_ROOT;
				end
				S_ROOT: begin
					hi_q    <= '0;
					sel_q   <= 1'b0;
					sw_q    <= '0;
					found_q <= 1'b0;
					state_q <= S_FIND;
				end
				S_FIND: begin
					if (vld_s1 && inb_rd_q && !rd_in_bkt) begin
						if (!found_q || dist_rd_q < dmin_q) dmin_q <= dist_rd_q;
						found_q <= 1'b1;
					end
					if (sw_done) begin
						if (found_q) begin
							rem_q   <= '0;
							dsh_q   <= dmin_q;
							dcnt_q  <= '0;
							state_q <= S_DIV;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				S_DIV: begin
					rem_q  <= drem;
					dsh_q  <= {dsh_q[DIST_BITS-2:0], 1'b0};
					dcnt_q <= dcnt_q + DCW'(1);
					if (dcnt_q == DCW'(DIST_BITS - 1)) state_q <= S_BND;
				end
				S_BND: begin
					hi_q    <= HW'(dmin_q) - HW'(rem_q) + HW'(delta_w);
					sw_q    <= '0;
					state_q <= S_MARK;
				end
				S_MARK: begin
					if (sw_done) begin
						v_q     <= '0;
						any_q   <= 1'b0;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (v_q == n_w) begin
						v_q <= '0;
						if (any_q) begin
							sel_q <= !sel_q;
							any_q <= 1'b0;
						end else begin
							sw_q    <= '0;
							found_q <= 1'b0;
							state_q <= S_FIND;
						end
					end else begin
						state_q <= S_CHK;
					end
				end
				S_CHK: begin
					dv_q   <= dist_rd_q;
					link_q <= head_rd_q;
					if (act_rd && head_rd_q != '0) begin
						state_q <= S_EDGE;
					end else begin
						v_q     <= v_q + NW'(1);
						state_q <= S_SCAN;
					end
				end
				S_EDGE: begin
					state_q <= S_EDGEW;
				end
				S_EDGEW: begin
					cand_q  <= cand_w;
					tgt_q   <= etgt_rd_q;
					tok_q   <= 32'(etgt_rd_q) < 32'(n_w);
					nxt_q   <= enext_rd_q;
					state_q <= S_TGT;
				end
				S_TGT: begin
					if (tok_q && cand_q < dist_rd_q && HW'(cand_q) < hi_q) any_q <= 1'b1;
					link_q <= nxt_q;
					if (nxt_q != '0) begin
						state_q <= S_EDGE;
					end else begin
						v_q     <= v_q + NW'(1);
						state_q <= S_SCAN;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= LW'(MAX_EDGES))
		else $error("edge fill beyond store size");

	a_add_follow: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && in_ch.data.mode == dssp_pkg::MODE_ADD) |=> (state_q == S_ADD || out_valid_q))
		else $error("accepted add neither stored nor refused");

	a_bound_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MARK) |-> (hi_q != '0))
		else $error("bucket bound is zero while marking");

	a_relax_from_edge: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_TGT) |-> ($past(state_q) == S_EDGEW))
		else $error("target compare without edge read");

endmodule

`default_nettype wire

// File: sim/tb.sv
`timescale 1ns / 1ps

module tb;

	localparam logic [dssp_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;
	localparam int NV = 1024;
	localparam int NE = 4096;
	localparam logic [dssp_pkg::DIST_W-1:0] UNREACHABLE = '1;
	localparam longint CYCLE_LIMIT = 100_000_000;
	localparam int TAIL_CYCLES = 12;
	localparam int BURST_LEN = 112;

	class path_scoreboard;
		logic [dssp_pkg::ROOT_W-1:0]   root;
		logic [dssp_pkg::BWIDTH_W-1:0] bwidth;
		logic [dssp_pkg::VCOUNT_W-1:0] vcount;
		logic [dssp_pkg::DIST_W-1:0]   path_len [NV];
		logic [12:0]                   head [NV];
		logic [12:0]                   link_next [NE];
		logic [dssp_pkg::VID_W-1:0]    target [NE];
		logic [dssp_pkg::WEIGHT_W-1:0] wgt [NE];
		bit                            queued [NV];
		bit                            active [NV];
		bit                            refill [NV];
		int                            edges_held;
		dssp_pkg::out_item_t           awaited [$];
		int                            errors;
		int                            n_adds, n_full, n_runs, n_reads;

		function new();
			root = 0;
			bwidth = 4;
			vcount = 1024;
			edges_held = 0;
			errors = 0;
			foreach (path_len[i]) begin
				path_len[i] = 0;
				head[i] = 0;
				queued[i] = 0;
				active[i] = 0;
			end
		endfunction

		function void set_reg(logic [dssp_pkg::CFG_IDX_W-1:0] idx,
			logic [dssp_pkg::CFG_DATA_W-1:0] val);
			case (idx)
				dssp_pkg::CFG_ROOT: root = val[dssp_pkg::ROOT_W-1:0];
				dssp_pkg::CFG_BWIDTH: bwidth = val[dssp_pkg::BWIDTH_W-1:0];
				dssp_pkg::CFG_VCOUNT: vcount = val[dssp_pkg::VCOUNT_W-1:0];
				default: ;
			endcase
		endfunction

		function int in_use();
			if (vcount == 0) return 1;
			if (vcount > NV) return NV;
			return vcount;
		endfunction

		function longint unsigned path_sum(longint unsigned d, longint unsigned w);
			longint unsigned ones;
			ones = UNREACHABLE;
			if (w >= ones - d) return ones - 1;
			return d + w;
		endfunction

		function void solve_paths();
			int n;
			longint unsigned delta, k, b, cand;
			bit found, any;
			int lnk, steps, e, t;
			n = in_use();
			delta = (bwidth == 0) ? 1 : bwidth;
			for (int v = 0; v < NV; v++) begin
				path_len[v] = UNREACHABLE;
				queued[v] = 0;
				active[v] = 0;
			end
			if (root < n) begin
				path_len[root] = 0;
				queued[root] = 1;
			end
			forever begin
				found = 0;
				k = 0;
				for (int v = 0; v < n; v++)
					if (queued[v]) begin
						b = path_len[v] / delta;
						if (!found || b < k) begin
							k = b;
							found = 1;
						end
					end
				if (!found) break;
				any = 0;
				for (int v = 0; v < n; v++) begin
					active[v] = queued[v] && (path_len[v] / delta == k);
					any = any || active[v];
				end
				while (any) begin
					foreach (refill[i]) refill[i] = 0;
					for (int v = 0; v < n; v++) begin
						if (!active[v]) continue;
						lnk = head[v];
						steps = 0;
						while (lnk != 0 && lnk <= edges_held && steps < NE) begin
							e = lnk - 1;
							t = target[e];
							if (t < n) begin
								cand = path_sum(path_len[v], wgt[e]);
								if (cand < path_len[t]) begin
									path_len[t] = dssp_pkg::DIST_W'(cand);
									queued[t] = 1;
									if (cand / delta == k) refill[t] = 1;
								end
							end
							lnk = link_next[e];
							steps++;
						end
					end
					any = 0;
					for (int v = 0; v < n; v++) begin
						active[v] = refill[v];
						any = any || refill[v];
					end
				end
				for (int v = 0; v < n; v++)
					if (queued[v] && path_len[v] / delta == k) queued[v] = 0;
			end
		endfunction

		function void note_command(dssp_pkg::in_item_t it);
			dssp_pkg::out_item_t r;
			r.distance = 0;
			case (it.mode)
				dssp_pkg::MODE_ADD: begin
					if (edges_held >= NE) begin
						r.status = dssp_pkg::ST_EDGE_FULL;
						n_full++;
					end else begin
						target[edges_held] = it.dst_vertex;
						wgt[edges_held] = it.weight;
						link_next[edges_held] = head[it.src_vertex];
						edges_held++;
						head[it.src_vertex] = 13'(edges_held);
						r.status = dssp_pkg::ST_EDGE_STORED;
						n_adds++;
					end
					awaited.insert(awaited.size(), r);
				end
				dssp_pkg::MODE_RUN: begin
					solve_paths();
					r.status = dssp_pkg::ST_RUN_DONE;
					n_runs++;
					awaited.insert(awaited.size(), r);
				end
				dssp_pkg::MODE_READ: begin
					r.status = dssp_pkg::ST_READ_DATA;
					r.distance = (it.src_vertex < in_use()) ? path_len[it.src_vertex]
						: UNREACHABLE;
					n_reads++;
					awaited.insert(awaited.size(), r);
				end
				default: ;
			endcase
		endfunction

		function void check_beat(dssp_pkg::out_item_t got);
			dssp_pkg::out_item_t want;
			if (awaited.size() == 0) begin
				$display("%0t: unexpected beat status %0d distance %0d", $time,
					got.status, got.distance);
				errors++;
				return;
			end
			want = awaited.pop_front();
			if (got.status !== want.status) begin
				$display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
				errors++;
			end
			if (got.distance !== want.distance) begin
				$display("%0t: distance expected %0d actual %0d", $time,
					want.distance, got.distance);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [dssp_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [dssp_pkg::CFG_DATA_W-1:0] cfg_wdata;
	int send_idle_pct;
	int stall_pct;
	longint cycles;
	path_scoreboard sb;

	dssp_in_if in_if ();
	dssp_out_if out_if ();

	delta_stepping_shortest_paths u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.in_ch(in_if),
		.out_ch(out_if)
	);

	initial begin
		clk = 0;
		arst_n = 0;
		cfg_we = 0;
		cfg_index = '0;
		cfg_wdata = '0;
		in_if.valid = 0;
		in_if.data = '0;
		out_if.ready = 0;
		send_idle_pct = 0;
		stall_pct = 0;
		cycles = 0;
		sb = new();
	end

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) out_if.ready <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && in_if.valid && in_if.ready) sb.note_command(in_if.data);
		if (arst_n && out_if.valid && out_if.ready) sb.check_beat(out_if.data);
	end

	function automatic dssp_pkg::in_item_t cmd(logic [dssp_pkg::MODE_W-1:0] m, int s, int d,
		int w);
		dssp_pkg::in_item_t it;
		it.mode = m;
		it.src_vertex = dssp_pkg::VID_W'(s);
		it.dst_vertex = dssp_pkg::VID_W'(d);
		it.weight = dssp_pkg::WEIGHT_W'(w);
		return it;
	endfunction

	function automatic int pick_vertex();
		if ($urandom_range(99) < 6) return $urandom_range(NV - 1);
		return $urandom_range(39);
	endfunction

	function automatic int pick_weight();
		int r;
		r = $urandom_range(99);
		if (r < 10) return 0;
		if (r < 20) return 65535;
		if (r < 60) return $urandom_range(15);
		return $urandom_range(65535);
	endfunction

	task automatic send(dssp_pkg::in_item_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			in_if.valid <= 0;
			@(posedge clk);
		end
		in_if.valid <= 1;
		in_if.data <= it;
		@(posedge clk);
		while (!in_if.ready) @(posedge clk);
	endtask

	task automatic drain();
		in_if.valid <= 0;
		do @(posedge clk); while (sb.awaited.size() != 0);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(logic [dssp_pkg::CFG_IDX_W-1:0] idx, int val);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_wdata <= dssp_pkg::CFG_DATA_W'(val);
		@(posedge clk);
		sb.set_reg(idx, dssp_pkg::CFG_DATA_W'(val));
	endtask

	task automatic set_up(int r, int bw, int vc, int mode_sel);
		drain();
		cfg_write(dssp_pkg::CFG_ROOT, r);
		cfg_write(dssp_pkg::CFG_BWIDTH, bw);
		cfg_write(dssp_pkg::CFG_VCOUNT, vc);
		cfg_we <= 0;
		case (mode_sel)
			0: begin send_idle_pct = 0; stall_pct = 0; end
			1: begin send_idle_pct = 61; stall_pct = 0; end
			2: begin send_idle_pct = 0; stall_pct = 61; end
			default: begin send_idle_pct = 35; stall_pct = 35; end
		endcase
	endtask

	task automatic random_burst(int count);
		int r;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(99);
			if (r < 45) send(cmd(dssp_pkg::MODE_ADD, pick_vertex(), pick_vertex(),
				pick_weight()));
			else if (r < 50) send(cmd(dssp_pkg::MODE_RUN, $urandom_range(NV - 1),
				$urandom_range(NV - 1), $urandom_range(65535)));
			else if (r < 96) send(cmd(dssp_pkg::MODE_READ, pick_vertex(),
				$urandom_range(NV - 1), $urandom_range(65535)));
			else send(cmd(MODE_UNUSED, $urandom_range(NV - 1), $urandom_range(NV - 1),
				$urandom_range(65535)));
		end
	endtask

	initial begin
		int roots [9] = '{3, 5, 0, 1023, 40, 0, 2, 1, 7};
		int widths [9] = '{1, 65535, 0, 7, 100, 300, 50, 3, 65535};
		int counts [9] = '{16, 24, 32, 1024, 20, 0, 2047, 2, 40};
		#0;
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: small graph under reset settings
		send(cmd(dssp_pkg::MODE_ADD, 0, 1, 0));
		send(cmd(dssp_pkg::MODE_ADD, 0, 2, 65535));
		send(cmd(dssp_pkg::MODE_ADD, 1, 3, 5));
		send(cmd(dssp_pkg::MODE_ADD, 3, 1023, 1));
		send(cmd(dssp_pkg::MODE_ADD, 1023, 0, 3));
		send(cmd(dssp_pkg::MODE_ADD, 2, 2, 7));
		send(cmd(dssp_pkg::MODE_ADD, 1, 2, 65534));
		send(cmd(dssp_pkg::MODE_ADD, 3, 2, 2));
		send(cmd(dssp_pkg::MODE_RUN, 0, 0, 0));
		send(cmd(dssp_pkg::MODE_READ, 0, 0, 0));
		send(cmd(dssp_pkg::MODE_READ, 1, 0, 0));
		send(cmd(dssp_pkg::MODE_READ, 2, 1023, 65535));
		send(cmd(dssp_pkg::MODE_READ, 3, 0, 0));
		send(cmd(dssp_pkg::MODE_READ, 1023, 0, 0));
		send(cmd(dssp_pkg::MODE_READ, 500, 0, 0));
		send(cmd(MODE_UNUSED, 1023, 1023, 65535));
		send(cmd(dssp_pkg::MODE_ADD, 1023, 1023, 65535));
		send(cmd(dssp_pkg::MODE_RUN, 1023, 1023, 65535));
		send(cmd(dssp_pkg::MODE_READ, 2, 0, 0));

		// root outside count, zero width
		set_up(900, 0, 10, 0);
		send(cmd(dssp_pkg::MODE_RUN, 0, 0, 0));
		send(cmd(dssp_pkg::MODE_READ, 0, 0, 0));
		send(cmd(dssp_pkg::MODE_READ, 9, 0, 0));
		send(cmd(dssp_pkg::MODE_READ, 10, 0, 0));

		for (int p = 0; p < 9; p++) begin
			set_up(roots[p], widths[p], counts[p], p % 4);
			if (p == 3) send(cmd(dssp_pkg::MODE_RUN, 0, 0, 0));
			random_burst(BURST_LEN);
			send(cmd(dssp_pkg::MODE_RUN, 0, 0, 0));
			for (int v = 0; v < 6; v++) send(cmd(dssp_pkg::MODE_READ, pick_vertex(), 0, 0));
		end

		// final run over a small vertex range with both sides idling
		set_up(0, 16, 48, 3);
		send(cmd(dssp_pkg::MODE_RUN, 0, 0, 0));
		for (int v = 0; v < 48; v++) send(cmd(dssp_pkg::MODE_READ, v, 0, 0));

		drain();
		$display("covered %0d stored edges, %0d full rejects, %0d runs, %0d reads",
			sb.n_adds, sb.n_full, sb.n_runs, sb.n_reads);
		$display("nine register settings incl. zero width, zero and oversize vertex count");
		if (sb.errors == 0 && sb.awaited.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

// File: files.f
design/dssp_pkg.sv
design/dssp_if.sv
design/delta_stepping_shortest_paths.sv
sim/tb.sv
